// File: sv/smvm_pkg.sv
// ----------------------------------------------------------------------------
// smvm_pkg
// shared constants and types of the sparse matrix-vector multiply unit
// ----------------------------------------------------------------------------
package smvm_pkg;

    localparam int VEC_DEPTH = 1024;
    localparam int MAX_ROWS  = 65536;

    localparam int CMD_W   = 2;
    localparam int COL_W   = 10;
    localparam int VAL_W   = 32;
    localparam int ROW_W   = 16;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int ACC_W   = 64;
    localparam int FRAC_W  = 16;
    localparam int RND_W   = PROD_W - FRAC_W;

    localparam int VEC_AW  = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
    localparam int CEXT_W  = VEC_AW + COL_W;

    localparam int S_DATA_W = ((COL_W + VAL_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((ROW_W + VAL_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_NONZERO = 2'd1,
        CMD_EMPTY   = 2'd2,
        CMD_UNUSED  = 2'd3
    } t_cmd;

endpackage

// File: sv/sparse_matrix_vector_multiply_unit.sv
// ----------------------------------------------------------------------------
// sparse_matrix_vector_multiply_unit
// CSR matrix-vector product in Q16.16 with a vector RAM and 64-bit accumulator
// ----------------------------------------------------------------------------
//  channel | direction | tdata (low bit up)        | tuser      | tlast
//  s       | in        | col_index, data_value     | cmd        | row_end
//  m       | out       | row_number, row_sum       | saturated  | -
//
//  one transaction per cycle sustained while the output is not stalled; a row
//  result passes the RAM read at the accepting edge, then the multiply, the
//  accumulate and the clamp into the output register
//  the accumulator add is the loop that sets the one-cycle rate
//  reset clears the pipeline valids, the accumulator and the row counter;
//  the vector RAM is not cleared
//  a stalled output only blocks the input once every stage holds an item
// ----------------------------------------------------------------------------
module sparse_matrix_vector_multiply_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // col_index[9:0], data_value[41:10], zero fill
    input  logic [smvm_pkg::S_DATA_W-1:0] i_s_tdata,
    // cmd[1:0]
    input  logic [smvm_pkg::CMD_W-1:0]    i_s_tuser,
    input  logic                          i_s_tlast,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // row_number[15:0], row_sum[47:16]
    output logic [smvm_pkg::M_DATA_W-1:0] o_m_tdata,
    // saturated[0]
    output logic [0:0]                    o_m_tuser
);

    // input unpacking
    logic [smvm_pkg::COL_W-1:0]  s_col;
    logic [smvm_pkg::VAL_W-1:0]  s_val;
    smvm_pkg::t_cmd              s_cmd;
    logic [smvm_pkg::CEXT_W-1:0] s_col_ext;
    logic [smvm_pkg::VEC_AW-1:0] s_addr;
    logic                        s_in_range;
    logic                        s_accept;

    assign s_col      = i_s_tdata[smvm_pkg::COL_W-1:0];
    assign s_val      = i_s_tdata[smvm_pkg::COL_W+smvm_pkg::VAL_W-1:smvm_pkg::COL_W];
    assign s_cmd      = smvm_pkg::t_cmd'(i_s_tuser);
    assign s_col_ext  = smvm_pkg::CEXT_W'(s_col);
    assign s_addr     = s_col_ext[smvm_pkg::VEC_AW-1:0];
    assign s_in_range = s_col_ext < smvm_pkg::CEXT_W'(smvm_pkg::VEC_DEPTH);

    // stage enables, each stage moves when empty or when the next one moves
    logic en_out, en3, en2, en1;

    logic r_out_valid;
    logic r_s3_valid;
    logic r_s2_valid;
    logic r_s1_valid;

    assign en_out     = !r_out_valid || i_m_tready;
    assign en3        = !r_s3_valid || en_out;
    assign en2        = !r_s2_valid || en3;
    assign en1        = !r_s1_valid || en2;
    assign o_s_tready = en1;
    assign s_accept   = i_s_tvalid && en1;

    // vector RAM
    logic [smvm_pkg::VAL_W-1:0] r_vec_mem [smvm_pkg::VEC_DEPTH];
    logic [smvm_pkg::VAL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (s_accept && s_cmd == smvm_pkg::CMD_LOAD && s_in_range) begin
            r_vec_mem[s_addr] <= s_val;
        end
        if (en1) begin
            r_rd_data <= r_vec_mem[s_addr];
        end
    end

    // stage 1: RAM read in flight
    smvm_pkg::t_cmd             r_s1_cmd;
    logic [smvm_pkg::VAL_W-1:0] r_s1_val;
    logic                       r_s1_last;
    logic                       r_s1_in_range;
    logic                       s_to_pipe;

    assign s_to_pipe = s_cmd == smvm_pkg::CMD_NONZERO || s_cmd == smvm_pkg::CMD_EMPTY;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en1) begin
            r_s1_valid <= i_s_tvalid && s_to_pipe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_cmd      <= s_cmd;
            r_s1_val      <= s_val;
            r_s1_last     <= i_s_tlast;
            r_s1_in_range <= s_in_range;
        end
    end

    // stage 2: product register
    logic signed [smvm_pkg::VAL_W-1:0]  s1_elem;
    logic signed [smvm_pkg::PROD_W-1:0] r_s2_prod;
    logic                               r_s2_close;
    logic                               r_s2_empty;

    assign s1_elem = r_s1_in_range ? $signed(r_rd_data) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_prod  <= $signed(r_s1_val) * s1_elem;
            r_s2_empty <= r_s1_cmd == smvm_pkg::CMD_EMPTY;
            r_s2_close <= r_s1_cmd == smvm_pkg::CMD_EMPTY || r_s1_last;
        end
    end

    // accumulate: round half up to Q16.16, then saturating 64-bit add
    logic signed [smvm_pkg::ACC_W-1:0]  r_acc;
    logic signed [smvm_pkg::ACC_W-1:0]  n_acc;
    logic        [smvm_pkg::PROD_W-1:0] s2_biased;
    logic signed [smvm_pkg::ACC_W-1:0]  s2_rnd;
    logic signed [smvm_pkg::ACC_W-1:0]  s2_sum;
    logic        [smvm_pkg::ACC_W-1:0]  s2_raw;
    logic                               s2_ovf;
    logic signed [smvm_pkg::ACC_W-1:0]  s2_row_sum;
    logic                               s2_done;

    assign s2_biased = r_s2_prod + (smvm_pkg::PROD_W'(1) << (smvm_pkg::FRAC_W - 1));
    assign s2_rnd    = smvm_pkg::ACC_W'($signed(s2_biased[smvm_pkg::PROD_W-1:smvm_pkg::FRAC_W]));
    assign s2_raw    = r_acc + s2_rnd;
    assign s2_ovf    = (r_acc[smvm_pkg::ACC_W-1] == s2_rnd[smvm_pkg::ACC_W-1])
                    && (s2_raw[smvm_pkg::ACC_W-1] != s2_rnd[smvm_pkg::ACC_W-1]);

    always_comb begin
        if (!s2_ovf) begin
            s2_sum = $signed(s2_raw);
        end else if (s2_rnd[smvm_pkg::ACC_W-1]) begin
            s2_sum = {1'b1, {(smvm_pkg::ACC_W-1){1'b0}}};
        end else begin
            s2_sum = {1'b0, {(smvm_pkg::ACC_W-1){1'b1}}};
        end
    end

    assign s2_row_sum = r_s2_empty ? r_acc : s2_sum;
    assign s2_done    = r_s2_valid && en3;

    always_comb begin
        n_acc = r_acc;
        if (s2_done) begin
            n_acc = r_s2_close ? '0 : s2_sum;
        end
    end

    // stage 3: finished row sum waiting for the clamp
    logic signed [smvm_pkg::ACC_W-1:0] r_s3_sum;
    logic        [smvm_pkg::ROW_W-1:0] r_s3_row;
    logic        [smvm_pkg::ROW_W-1:0] r_row;
    logic        [smvm_pkg::ROW_W-1:0] n_row;

    always_comb begin
        n_row = r_row;
        if (s2_done && r_s2_close) begin
            if (r_row == smvm_pkg::ROW_W'(smvm_pkg::MAX_ROWS - 1)) begin
                n_row = '0;
            end else begin
                n_row = r_row + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_row      <= '0;
            r_s3_valid <= 1'b0;
        end else begin
            r_acc <= n_acc;
            r_row <= n_row;
            if (en3) begin
                r_s3_valid <= r_s2_valid && r_s2_close;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_sum <= s2_row_sum;
            r_s3_row <= r_row;
        end
    end

    // clamp into the output register
    logic                       s3_clip;
    logic [smvm_pkg::VAL_W-1:0] s3_clamped;
    logic [smvm_pkg::VAL_W-1:0] r_out_sum;
    logic [smvm_pkg::ROW_W-1:0] r_out_row;
    logic                       r_out_sat;

    // value fits in 32 bits only when the top bits are all sign copies
    assign s3_clip = !(&r_s3_sum[smvm_pkg::ACC_W-1:smvm_pkg::VAL_W-1])
                  && (|r_s3_sum[smvm_pkg::ACC_W-1:smvm_pkg::VAL_W-1]);

    always_comb begin
        if (!s3_clip) begin
            s3_clamped = r_s3_sum[smvm_pkg::VAL_W-1:0];
        end else if (r_s3_sum[smvm_pkg::ACC_W-1]) begin
            s3_clamped = {1'b1, {(smvm_pkg::VAL_W-1){1'b0}}};
        end else begin
            s3_clamped = {1'b0, {(smvm_pkg::VAL_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_sum <= s3_clamped;
            r_out_row <= r_s3_row;
            r_out_sat <= s3_clip;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = smvm_pkg::M_DATA_W'({r_out_sum, r_out_row});
    assign o_m_tuser  = r_out_sat;

    // input only stalls once the whole pipeline is full
    a_full_when_stalled : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_s1_valid && r_s2_valid && r_s3_valid && r_out_valid))
        else $error("input stalled with a free pipeline stage");

    // closing a row leaves a clear accumulator
    a_acc_cleared : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_done && r_s2_close) |=> (r_acc == '0))
        else $error("accumulator not cleared after row end");

    // a clipped result sits at one of the 32-bit limits
    a_sat_limits : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_sat) |->
            (r_out_sum == 32'h7fff_ffff || r_out_sum == 32'h8000_0000))
        else $error("saturated flag with an unclipped row sum");

    // the row counter moves only when a row is closed
    a_row_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s2_done && r_s2_close) |=> $stable(r_row))
        else $error("row counter moved without a row end");

endmodule

// File: tb/sv/sparse_matrix_vector_multiply_unit_test.sv
// ----------------------------------------------------------------------------
// sparse_matrix_vector_multiply_unit_test
// self-checking bench for the CSR sparse matrix-vector multiply unit: a
// directed set of vector loads and rows, then random well-formed rows with
// noise; every row result is checked against a Q16.16 row-sum predictor
// kept in the bench
// ----------------------------------------------------------------------------
module sparse_matrix_vector_multiply_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     RANDOM_ITEMS = 1650;
    localparam int     MAX_IDLE     = 30;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     DRAIN_CYCLES = 16;
    localparam longint SUM_MAX      = 64'sd2147483647;
    localparam longint SUM_MIN      = -64'sd2147483648;
    localparam longint ACC_MAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_MIN      = 64'sh8000_0000_0000_0000;

    typedef struct {
        smvm_pkg::t_cmd             cmd;
        logic [smvm_pkg::COL_W-1:0] col;
        logic [smvm_pkg::VAL_W-1:0] value;
        logic                       row_end;
    } t_matrix_item;

    typedef struct {
        logic [smvm_pkg::ROW_W-1:0] row;
        logic [smvm_pkg::VAL_W-1:0] sum;
        logic                       sat;
    } t_row_result;

    logic                          i_clk      = 1'b0;
    logic                          i_rst_n    = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [smvm_pkg::S_DATA_W-1:0] i_s_tdata  = '0;
    logic [smvm_pkg::CMD_W-1:0]    i_s_tuser  = '0;
    logic                          i_s_tlast  = 1'b0;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [smvm_pkg::M_DATA_W-1:0] o_m_tdata;
    logic [0:0]                    o_m_tuser;

    t_matrix_item pending_items[$];
    t_row_result  expected_rows[$];

    // predictor state
    logic [smvm_pkg::VAL_W-1:0] vec_mirror [smvm_pkg::VEC_DEPTH];
    longint                     acc_model = 0;
    logic [smvm_pkg::ROW_W-1:0] row_model = '0;

    // stimulus bookkeeping
    bit               col_loaded [smvm_pkg::VEC_DEPTH];
    int               loaded_cols[$];
    int               useful_items = 0;

    int               error_count  = 0;
    int               rows_checked = 0;
    longint           cycle_count  = 0;
    longint           cycle_limit  = 64'd50_000_000;
    int               hold_left    = 0;
    bit               hold_done    = 1'b0;

    sparse_matrix_vector_multiply_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // close the running row: clamp to 32 bits, clear, advance the row count
    function automatic void close_row();
        t_row_result res;
        res.row = row_model;
        res.sat = 1'b1;
        if (acc_model > SUM_MAX) begin
            res.sum = 32'h7FFF_FFFF;
        end else if (acc_model < SUM_MIN) begin
            res.sum = 32'h8000_0000;
        end else begin
            res.sum = acc_model[31:0];
            res.sat = 1'b0;
        end
        expected_rows = {expected_rows, res};
        acc_model = 0;
        row_model = row_model + 16'd1;
    endfunction

    function automatic void predict_row_sum(input t_matrix_item it);
        longint           elem;
        longint           prod;
        longint           term;
        logic signed [64:0] wide;
        case (it.cmd)
            smvm_pkg::CMD_LOAD: begin
                vec_mirror[it.col] = it.value;
            end
            smvm_pkg::CMD_NONZERO: begin
                elem = longint'($signed(vec_mirror[it.col]));
                prod = longint'($signed(it.value)) * elem;
                // round half up to Q16.16
                term = (prod + 64'sd32768) >>> 16;
                wide = $signed({acc_model[63], acc_model}) + $signed({term[63], term});
                if (wide[64] != wide[63]) begin
                    acc_model = wide[64] ? ACC_MIN : ACC_MAX;
                end else begin
                    acc_model = wide[63:0];
                end
                if (it.row_end) begin
                    close_row();
                end
            end
            smvm_pkg::CMD_EMPTY: begin
                close_row();
            end
            default: begin
            end
        endcase
    endfunction

    function automatic logic [smvm_pkg::VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return $urandom;
        if (r < 70) return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
        if (r < 88) return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0001_0000;
            default: return 32'h0000_8000;
        endcase
    endfunction

    // mostly back to back, now and then a short or a long pause
    function automatic int pick_idle(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 95) return $urandom_range(1, 2);
        return $urandom_range(6, MAX_IDLE);
    endfunction

    function automatic void add_item(input smvm_pkg::t_cmd c, input int col,
                                     input logic [smvm_pkg::VAL_W-1:0] v, input bit last);
        t_matrix_item it;
        it.cmd     = c;
        it.col     = smvm_pkg::COL_W'(col);
        it.value   = v;
        it.row_end = last;
        pending_items = {pending_items, it};
        if (c != smvm_pkg::CMD_UNUSED) useful_items++;
        if (c == smvm_pkg::CMD_LOAD && !col_loaded[it.col]) begin
            col_loaded[it.col] = 1'b1;
            loaded_cols = {loaded_cols, int'(it.col)};
        end
    endfunction

    function automatic int loaded_col();
        return loaded_cols[$urandom_range(0, loaded_cols.size() - 1)];
    endfunction

    // ------------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------------
    int send_gap       = 0;
    int send_calm_left = 0;

    always @(posedge i_clk) begin : sender
        bit           busy;
        t_matrix_item it;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            busy = i_s_tvalid;
            if (send_calm_left > 0) begin
                send_calm_left--;
            end else if ($urandom_range(0, 499) == 0) begin
                send_calm_left = $urandom_range(50, 200);
            end
            if (i_s_tvalid && o_s_tready) begin
                predict_row_sum(pending_items.pop_front());
                busy     = 1'b0;
                send_gap = pick_idle(send_calm_left > 0);
            end
            if (!busy) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_items.size() != 0) begin
                    busy = 1'b1;
                end
            end
            if (busy && !i_s_tvalid || busy && i_s_tvalid && o_s_tready) begin
                it = pending_items[0];
                i_s_tdata <= {{(smvm_pkg::S_DATA_W - smvm_pkg::COL_W - smvm_pkg::VAL_W){1'b0}},
                              it.value, it.col};
                i_s_tuser <= it.cmd;
                i_s_tlast <= it.row_end;
            end else if (!busy) begin
                // junk on the idle bus
                i_s_tdata <= smvm_pkg::S_DATA_W'({$urandom, $urandom});
                i_s_tuser <= smvm_pkg::CMD_W'($urandom);
                i_s_tlast <= 1'($urandom);
            end
            i_s_tvalid <= busy;
        end
    end

    // ------------------------------------------------------------------------
    // receiver and checker
    // ------------------------------------------------------------------------
    int recv_stall     = 0;
    int recv_calm_left = 0;

    always @(posedge i_clk) begin : receiver
        t_row_result got;
        t_row_result want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (recv_calm_left > 0) begin
                recv_calm_left--;
            end else if ($urandom_range(0, 499) == 0) begin
                recv_calm_left = $urandom_range(50, 200);
            end
            if (o_m_tvalid && i_m_tready) begin
                got.row = o_m_tdata[smvm_pkg::ROW_W-1:0];
                got.sum = o_m_tdata[smvm_pkg::ROW_W+smvm_pkg::VAL_W-1:smvm_pkg::ROW_W];
                got.sat = o_m_tuser[0];
                rows_checked <= rows_checked + 1;
                if (expected_rows.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected row result: row %0d sum %h sat %0b",
                                 got.row, got.sum, got.sat);
                end else begin
                    want = expected_rows.pop_front();
                    if (got.row !== want.row || got.sum !== want.sum
                        || got.sat !== want.sat) begin
                        error_count++;
                        if (error_count <= 10)
                            $display({"row mismatch: expected row %0d sum %h sat %0b, ",
                                      "got row %0d sum %h sat %0b"},
                                     want.row, want.sum, want.sat,
                                     got.row, got.sum, got.sat);
                    end
                end
                recv_stall = pick_idle(recv_calm_left > 0);
            end else if (recv_stall == 0 && recv_calm_left == 0
                         && $urandom_range(0, 9) == 0) begin
                recv_stall = pick_idle(1'b0);
            end
            if (recv_stall > 0) begin
                recv_stall--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= (hold_left == 0);
            end
        end
    end

    // one long hold-off on the result side so the pipe fills and backs up
    always @(posedge i_clk) begin
        if (!hold_done && rows_checked >= 40) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    initial begin
        while (cycle_count < cycle_limit) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int r;
        int len;
        int n;

        // directed: extremes, rounding, load mid-row, ignored code
        add_item(smvm_pkg::CMD_UNUSED,  1023, 32'hFFFF_FFFF, 1'b1);
        add_item(smvm_pkg::CMD_EMPTY,   0,    32'h0000_0000, 1'b0);
        add_item(smvm_pkg::CMD_LOAD,    0,    32'h0001_0000, 1'b0);
        add_item(smvm_pkg::CMD_LOAD,    1023, 32'h7FFF_FFFF, 1'b1);
        add_item(smvm_pkg::CMD_LOAD,    1,    32'h8000_0000, 1'b0);
        add_item(smvm_pkg::CMD_LOAD,    2,    32'hFFFF_FFFF, 1'b1);
        add_item(smvm_pkg::CMD_NONZERO, 0,    32'h0002_0000, 1'b1);
        add_item(smvm_pkg::CMD_NONZERO, 1023, 32'h7FFF_FFFF, 1'b0);
        add_item(smvm_pkg::CMD_NONZERO, 1023, 32'h7FFF_FFFF, 1'b1);
        add_item(smvm_pkg::CMD_NONZERO, 1,    32'h7FFF_FFFF, 1'b1);
        add_item(smvm_pkg::CMD_NONZERO, 1,    32'h8000_0000, 1'b1);
        // exact halves round up
        add_item(smvm_pkg::CMD_NONZERO, 2,    32'h0000_8000, 1'b1);
        add_item(smvm_pkg::CMD_NONZERO, 2,    32'hFFFF_8000, 1'b1);
        add_item(smvm_pkg::CMD_NONZERO, 2,    32'h0000_0001, 1'b1);
        // a load in the middle of a row leaves the sum alone
        add_item(smvm_pkg::CMD_NONZERO, 0,    32'h0003_0000, 1'b0);
        add_item(smvm_pkg::CMD_LOAD,    0,    32'hFFFF_0000, 1'b0);
        add_item(smvm_pkg::CMD_NONZERO, 0,    32'h0001_0000, 1'b1);
        add_item(smvm_pkg::CMD_NONZERO, 1023, 32'h0000_0000, 1'b0);
        add_item(smvm_pkg::CMD_UNUSED,  5,    32'h1234_5678, 1'b1);
        add_item(smvm_pkg::CMD_NONZERO, 2,    32'hFFFF_FFFF, 1'b0);
        // empty row closes what is pending, then a true empty row
        add_item(smvm_pkg::CMD_EMPTY,   0,    32'h0000_0000, 1'b1);
        add_item(smvm_pkg::CMD_EMPTY,   1023, 32'hFFFF_FFFF, 1'b1);

        n = useful_items + RANDOM_ITEMS;
        while (useful_items < n) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    add_item(smvm_pkg::CMD_LOAD, $urandom_range(0, smvm_pkg::VEC_DEPTH - 1),
                             pick_value(), 1'($urandom));
            end else if (r < 16) begin
                add_item(smvm_pkg::CMD_UNUSED, $urandom_range(0, 1023), $urandom,
                         1'($urandom));
            end else if (r < 24) begin
                add_item(smvm_pkg::CMD_EMPTY, $urandom_range(0, 1023), $urandom,
                         1'($urandom));
            end else if (r < 30) begin
                // row left open and closed by an empty-row transaction
                len = $urandom_range(1, 3);
                for (int k = 0; k < len; k++)
                    add_item(smvm_pkg::CMD_NONZERO, loaded_col(), pick_value(), 1'b0);
                add_item(smvm_pkg::CMD_EMPTY, $urandom_range(0, 1023), $urandom,
                         1'($urandom));
            end else begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(0, 9) == 0)
                        add_item(smvm_pkg::CMD_LOAD, loaded_col(), pick_value(),
                                 1'($urandom));
                    add_item(smvm_pkg::CMD_NONZERO, loaded_col(), pick_value(),
                             k == len - 1);
                end
            end
        end

        cycle_limit = longint'(pending_items.size()) * (2 * MAX_IDLE + 8) * 3
                      + HOLD_CYCLES + 10000;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_s_tvalid) @(posedge i_clk);
        while (expected_rows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_rows.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
